// ===== hdl/hkt_pkg.sv =====
// Shared types and constants for the pair key hash table.
`default_nettype none

package hkt_pkg;

   localparam logic [63:0] HASH_MASK    = 64'h0000_0000_7FFF_FFF8;
   localparam int          HASH_DROP    = 3;
   localparam int          FIRST_STRIDE = 7;
   localparam int          LOAD_NUM     = 5;
   localparam int          LOAD_DEN     = 4;

   localparam logic [3:0] SIZE_LOG2_MIN   = 4'd3;
   localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_READ,
      FSM_CHECK,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       step;
      logic       write_new;
      logic       write_value;
      logic       record;
      status_type code;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic key_zero;
      logic req_lookup;
      logic is_lookup;
      logic hit;
      logic empty;
      logic probe_last;
      logic room;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/hkt_ifs.sv =====
// Channel interfaces for request, response and control register words.
`default_nettype none

interface hkt_req_if #(
   parameter int KEY_BITS = 32
);
   logic                valid;
   logic                ready;
   logic                operation;
   logic [KEY_BITS-1:0] name_key;
   logic [KEY_BITS-1:0] space_key;
   logic [31:0]         bind_value;

   modport source (output valid, output operation, output name_key, output space_key,
                   output bind_value, input ready);
   modport sink   (input valid, input operation, input name_key, input space_key,
                   input bind_value, output ready);
endinterface

interface hkt_rsp_if #(
   parameter int SLOT_BITS = 10
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           status;
   logic [31:0]          found_value;
   logic [SLOT_BITS-1:0] slot_index;

   modport source (output valid, output status, output found_value, output slot_index,
                   input ready);
   modport sink   (input valid, input status, input found_value, input slot_index,
                   output ready);
endinterface

interface hkt_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] size_log2;

   modport source (output valid, output size_log2, input ready);
   modport sink   (input valid, input size_log2, output ready);
endinterface

`default_nettype wire

// ===== hdl/hkt_ctrl.sv =====
// Controller state machine that sequences clearing, probing and response hand-off.
`default_nettype none

module hkt_ctrl
   import hkt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   fsm_type state_ff;
   fsm_type state_in;
   logic    probe_done;

   assign probe_done = stat.hit || stat.empty || stat.probe_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: begin
            if (stat.clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = stat.key_zero ? FSM_FINISH : FSM_READ;
            end
         end
         FSM_READ: begin
            state_in = FSM_CHECK;
         end
         FSM_CHECK: begin
            state_in = probe_done ? FSM_FINISH : FSM_READ;
         end
         FSM_FINISH: begin
            if (stat.rsp_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = ST_NOT_FOUND;
      case (state_ff)
         FSM_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && stat.key_zero) begin
               cmd.record = 1'b1;
               cmd.code   = stat.req_lookup ? ST_NOT_FOUND : ST_FULL;
            end
         end
         FSM_CHECK: begin
            cmd.step   = !probe_done;
            cmd.record = probe_done;
            if (stat.is_lookup) begin
               cmd.code = stat.hit ? ST_FOUND : ST_NOT_FOUND;
            end else if (stat.hit) begin
               cmd.code        = ST_UPDATED;
               cmd.write_value = 1'b1;
            end else if (stat.empty && stat.room) begin
               cmd.code      = ST_INSERTED;
               cmd.write_new = 1'b1;
            end else begin
               cmd.code = ST_FULL;
            end
         end
         FSM_FINISH: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
            cmd.code = ST_NOT_FOUND;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/hkt_datapath.sv =====
// Datapath with slot memories, probe registers, entry count and response register.
`default_nettype none

module hkt_datapath
   import hkt_pkg::*;
#(
   parameter int MAX_SLOTS_LOG2 = 10,
   parameter int KEY_BITS       = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   input  wire logic [3:0]                csr_size_log2,
   input  wire logic                      req_operation,
   input  wire logic [KEY_BITS-1:0]       req_name_key,
   input  wire logic [KEY_BITS-1:0]       req_space_key,
   input  wire logic [31:0]               req_bind_value,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic [31:0]                    rsp_found_value,
   output logic [MAX_SLOTS_LOG2-1:0]      rsp_slot_index,
   input  wire cmd_type                   cmd,
   output stat_type                       stat
);

   localparam int SB = MAX_SLOTS_LOG2;
   localparam int CW = MAX_SLOTS_LOG2 + 4;
   localparam logic [4:0] MAX_L2 = 5'(MAX_SLOTS_LOG2);

   logic [KEY_BITS-1:0] mem_name  [2**SB];
   logic [KEY_BITS-1:0] mem_space [2**SB];
   logic [31:0]         mem_value [2**SB];

   logic [3:0]          size_log2_ff;
   logic [SB-1:0]       clr_ff;
   logic                op_ff;
   logic [KEY_BITS-1:0] name_ff;
   logic [KEY_BITS-1:0] space_ff;
   logic [31:0]         value_ff;
   logic [SB-1:0]       slot_ff;
   logic [SB-1:0]       stride_ff;
   logic [SB:0]         probes_ff;
   logic [SB:0]         count_ff;
   logic [KEY_BITS-1:0] rd_name_ff;
   logic [KEY_BITS-1:0] rd_space_ff;
   logic [31:0]         rd_value_ff;
   status_type          status_ff;
   logic [31:0]         fval_ff;
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [31:0]         rsp_fval_ff;
   logic [SB-1:0]       rsp_slot_ff;

   logic [4:0]          eff_log2;
   logic [SB-1:0]       slot_mask;
   logic [SB:0]         table_size;
   logic [63:0]         hashed;
   logic [SB-1:0]       home_slot;
   logic [SB:0]         probes_next;
   logic [CW-1:0]       count_next;
   logic [CW-1:0]       load_lhs;
   logic [CW-1:0]       load_rhs;

   always_comb begin
      if (size_log2_ff < SIZE_LOG2_MIN) begin
         eff_log2 = {1'b0, SIZE_LOG2_MIN};
      end else if ({1'b0, size_log2_ff} > MAX_L2) begin
         eff_log2 = MAX_L2;
      end else begin
         eff_log2 = {1'b0, size_log2_ff};
      end
   end

   assign slot_mask   = ~({SB{1'b1}} << eff_log2);
   assign table_size  = {{SB{1'b0}}, 1'b1} << eff_log2;
   assign hashed      = (64'(req_name_key) & HASH_MASK) >> HASH_DROP;
   assign home_slot   = hashed[SB-1:0] & slot_mask;
   assign probes_next = probes_ff + 1'b1;
   assign count_next  = CW'(count_ff) + CW'(1);
   assign load_lhs    = CW'(count_next * LOAD_NUM);
   assign load_rhs    = CW'(CW'(table_size) * LOAD_DEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
      end else if (csr_valid) begin
         size_log2_ff <= csr_size_log2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.write_new) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         name_ff   <= req_name_key;
         space_ff  <= req_space_key;
         value_ff  <= req_bind_value;
         slot_ff   <= home_slot;
         stride_ff <= SB'(FIRST_STRIDE);
         probes_ff <= '0;
      end else if (cmd.step) begin
         slot_ff   <= (slot_ff + stride_ff) & slot_mask;
         stride_ff <= stride_ff + 1'b1;
         probes_ff <= probes_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem_name[clr_ff] <= '0;
      end else if (cmd.write_new) begin
         mem_name[slot_ff] <= name_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         mem_space[slot_ff] <= space_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new || cmd.write_value) begin
         mem_value[slot_ff] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_name_ff  <= mem_name[slot_ff];
      rd_space_ff <= mem_space[slot_ff];
      rd_value_ff <= mem_value[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.record) begin
         status_ff <= cmd.code;
         fval_ff   <= (cmd.code == ST_FOUND) ? rd_value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_fval_ff   <= fval_ff;
         rsp_slot_ff   <= slot_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   always_comb begin
      stat            = '0;
      stat.clear_last = &clr_ff;
      stat.key_zero   = (req_name_key == '0);
      stat.req_lookup = req_operation;
      stat.is_lookup  = op_ff;
      stat.hit        = (rd_name_ff == name_ff) && (rd_space_ff == space_ff);
      stat.empty      = (rd_name_ff == '0);
      stat.probe_last = (probes_next >= table_size);
      stat.room       = (load_lhs < load_rhs);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ===== hdl/pair_key_hash_table.sv =====
// Top level of the pair key hash table with its controller and datapath.
//
//   Channel  Dir  Word carried
//   req_if   in   operation, name_key, space_key, bind_value
//   rsp_if   out  status, found_value, slot_index
//   csr_if   in   size_log2
//
// After reset a clearing pass empties all 2**MAX_SLOTS_LOG2 slots, one a cycle,
// with req_if.ready low; csr_if is always ready.
// An item is taken in IDLE, then probes slots, each with a memory read state (READ)
// and a compare state (CHECK), and ends in FINISH; a zero name skips the probes.
// The response register holds a finished word while the next item is taken; the
// block only stalls when a second result is ready before the first is taken.
`default_nettype none

module pair_key_hash_table
   import hkt_pkg::*;
#(
   parameter int MAX_SLOTS_LOG2 = 10,
   parameter int KEY_BITS       = 32
) (
   input wire logic clock,
   input wire logic reset,
   hkt_req_if.sink   req_if,
   hkt_rsp_if.source rsp_if,
   hkt_csr_if.sink   csr_if
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_if.ready = 1'b1;

   hkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hkt_datapath #(
      .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2),
      .KEY_BITS       (KEY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_if.valid),
      .csr_size_log2   (csr_if.size_log2),
      .req_operation   (req_if.operation),
      .req_name_key    (req_if.name_key),
      .req_space_key   (req_if.space_key),
      .req_bind_value  (req_if.bind_value),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_found_value (rsp_if.found_value),
      .rsp_slot_index  (rsp_if.slot_index),
      .cmd             (cmd),
      .stat            (stat)
   );

   a_clear_blocks_req: assert property (@(posedge clock)
      $fell(reset) |-> !req_if.ready)
      else $error("request accepted during the clearing pass");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("second word accepted while an item is in progress");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_if.valid)
      else $error("response load did not raise valid");

endmodule

`default_nettype wire
